### rtl/bba_pkg.sv
// Package for the bitmap block allocator: sizes, op and status codes,
// controller/datapath command and status structs, mask helpers.
// No dependencies.
package bba_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 1024;
  localparam int INODE_BYTES = 128;
  localparam int WORD_BITS   = 32;

  localparam int MAP_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int BIDX_W    = $clog2(WORD_BITS);
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int BLK_W  = 10;
  localparam int CNT_W  = 11;
  localparam int INO_W  = 13;
  localparam int ST_W   = 2;
  localparam int META_W = 24;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // ops
  localparam logic [OP_W-1:0] OP_FORMAT = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd4;

  // result status
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

  // register index (paddr bit 2)
  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_INODES = 1'b1;

  localparam logic [CNT_W-1:0] TOTAL_RST  = 11'd1024;
  localparam logic [INO_W-1:0] INODES_RST = 13'd256;

  // kind of result staged for the commit cycle
  typedef enum logic [2:0] {
    PEND_FMT,
    PEND_MOD,
    PEND_ALLOC,
    PEND_NOFREE,
    PEND_RANGE,
    PEND_NOP
  } pend_e;

  typedef struct packed {
    logic  accept;
    logic  clr_map;
    logic  fmt_wr;
    logic  scan_start;
    logic  scan_step;
    logic  pend_en;
    pend_e pend_kind;
    logic  commit;
  } bba_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_range;
    logic            free_zero;
    logic            total_zero;
    logic            fmt_more;
    logic            fmt_last;
    logic            scan_hit;
    logic            scan_last;
    logic            slot_free;
  } bba_sts_t;

  // ones at bit positions of word idx whose block number is below limit
  function automatic logic [WORD_BITS-1:0] lim_mask(input logic [WIDX_W-1:0] idx,
                                                    input logic [CNT_W-1:0]  limit);
    logic [CNT_W-1:0]     base;
    logic [WORD_BITS-1:0] m;
    base = CNT_W'(idx) << BIDX_W;
    if (limit >= base + CNT_W'(WORD_BITS)) begin
      m = '1;
    end else if (limit > base) begin
      m = (WORD_BITS'(1) << limit[BIDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // index of the lowest zero bit (0 if none)
  function automatic logic [BIDX_W-1:0] low_zero(input logic [WORD_BITS-1:0] w);
    logic [BIDX_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) pos = BIDX_W'(i);
    end
    return pos;
  endfunction

endpackage

### rtl/bba_if.sv
// Handshake channels of the bitmap block allocator: request and response.
// Depends on bba_pkg.
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [BLK_W-1:0] block_number;
  logic             bit_value;

  modport source (output valid, op, block_number, bit_value, input ready);
  modport sink   (input valid, op, block_number, bit_value, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [BLK_W-1:0] block_out;
  logic             bit_read;
  logic [CNT_W-1:0] free_count;

  modport source (output valid, status, block_out, bit_read, free_count, input ready);
  modport sink   (input valid, status, block_out, bit_read, free_count, output ready);
endinterface

### rtl/bba_dp.sv
// Datapath: usage map memory with per-word valid bits, free count, scan
// pointers, staged result and response register. Depends on bba_pkg.
module bba_dp import bba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bba_cmd_t         cmd_i,
  output bba_sts_t         sts_o,
  input  logic [OP_W-1:0]  op_i,
  input  logic [BLK_W-1:0] blk_i,
  input  logic             bit_val_i,
  input  logic [CNT_W-1:0] total_i,
  input  logic [INO_W-1:0] inodes_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output logic [ST_W-1:0]  rsp_status_o,
  output logic [BLK_W-1:0] rsp_block_o,
  output logic             rsp_bit_o,
  output logic [CNT_W-1:0] rsp_free_o
);

  // latched request
  logic [OP_W-1:0]  op_q;
  logic [BLK_W-1:0] blk_q;
  logic             val_q;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rdvld_q;

  logic [WIDX_W-1:0] ptr_q, chk_q;
  logic [CNT_W-1:0]  free_q;

  // staged result
  logic                 pwr_q;
  logic [WIDX_W-1:0]    paddr_q;
  logic [WORD_BITS-1:0] pdata_q;
  logic [CNT_W-1:0]     pcnt_q;
  logic [ST_W-1:0]      pst_q;
  logic [BLK_W-1:0]     pbout_q;
  logic                 pbit_q;

  logic                 rsp_vld_q;
  logic [ST_W-1:0]      rsp_st_q;
  logic [BLK_W-1:0]     rsp_blk_q;
  logic                 rsp_bit_q;
  logic [CNT_W-1:0]     rsp_cnt_q;

  logic [WIDX_W-1:0]    blk_widx;
  logic [BIDX_W-1:0]    blk_bit;
  logic [WORD_BITS-1:0] blk_oh;
  logic [WIDX_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] word_eff;

  // format metadata size
  logic [META_W-1:0]    mb_bytes, ino_bytes, mb_blks, ino_blks, meta_raw;
  logic [CNT_W-1:0]     meta;

  logic [WORD_BITS-1:0] scan_word;
  logic [BIDX_W-1:0]    scan_pos;
  logic [CNT_W-1:0]     tot_m1;
  logic [WIDX_W-1:0]    last_widx;

  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  assign blk_widx = blk_q[BLK_W-1:BIDX_W];
  assign blk_bit  = blk_q[BIDX_W-1:0];
  assign blk_oh   = WORD_BITS'(1) << blk_bit;

  assign rd_addr  = cmd_i.scan_step ? ptr_q : (cmd_i.scan_start ? '0 : blk_widx);
  assign word_eff = rdvld_q ? rdata_q : '0;

  assign mb_bytes  = META_W'(total_i >> 3);
  assign ino_bytes = META_W'(inodes_i) * META_W'(INODE_BYTES);
  assign mb_blks   = (mb_bytes + META_W'(BLOCK_BYTES - 1)) >> BLK_SHIFT;
  assign ino_blks  = (ino_bytes + META_W'(BLOCK_BYTES - 1)) >> BLK_SHIFT;
  assign meta_raw  = META_W'(1) + mb_blks + ino_blks;
  assign meta      = (meta_raw > META_W'(total_i)) ? total_i : meta_raw[CNT_W-1:0];

  // blocks at or past the total read as used during the scan
  assign scan_word = word_eff | ~lim_mask(chk_q, total_i);
  assign scan_pos  = low_zero(scan_word);
  assign tot_m1    = total_i - CNT_W'(1);
  assign last_widx = tot_m1[BLK_W-1:BIDX_W];

  assign wr_en   = cmd_i.fmt_wr | (cmd_i.commit & pwr_q);
  assign wr_addr = cmd_i.fmt_wr ? ptr_q : paddr_q;
  assign wr_data = cmd_i.fmt_wr ? lim_mask(ptr_q, meta) : pdata_q;

  always_comb begin
    sts_o.op         = op_q;
    sts_o.in_range   = CNT_W'(blk_q) < total_i;
    sts_o.free_zero  = (free_q == '0);
    sts_o.total_zero = (total_i == '0);
    sts_o.fmt_more   = (CNT_W'(ptr_q) << BIDX_W) < meta;
    sts_o.fmt_last   = &ptr_q;
    sts_o.scan_hit   = ~&scan_word;
    sts_o.scan_last  = (chk_q == last_widx);
    sts_o.slot_free  = !rsp_vld_q || rsp_ready_i;
  end

  // map memory, read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rdata_q <= map_mem[rd_addr];
    rdvld_q <= vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      free_q    <= '0;
      ptr_q     <= '0;
      chk_q     <= '0;
      pwr_q     <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_map) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end

      if (cmd_i.clr_map) begin
        ptr_q <= '0;
      end else if (cmd_i.fmt_wr) begin
        ptr_q <= ptr_q + WIDX_W'(1);
      end else if (cmd_i.scan_start) begin
        ptr_q <= WIDX_W'(1);
        chk_q <= '0;
      end else if (cmd_i.scan_step) begin
        ptr_q <= ptr_q + WIDX_W'(1);
        chk_q <= ptr_q;
      end

      if (cmd_i.pend_en) begin
        pwr_q <= (cmd_i.pend_kind == PEND_ALLOC) ||
                 ((cmd_i.pend_kind == PEND_MOD) && (op_q != OP_READ));
      end

      if (cmd_i.commit) begin
        free_q    <= pcnt_q;
        rsp_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      blk_q <= blk_i;
      val_q <= bit_val_i;
    end

    if (cmd_i.pend_en) begin
      paddr_q <= blk_widx;
      pdata_q <= word_eff;
      pcnt_q  <= free_q;
      pst_q   <= ST_OK;
      pbout_q <= '0;
      pbit_q  <= 1'b0;
      unique case (cmd_i.pend_kind)
        PEND_FMT: begin
          pcnt_q <= total_i - meta;
        end
        PEND_MOD: begin
          priority if (op_q == OP_READ) begin
            pbit_q <= word_eff[blk_bit];
          end else if (op_q == OP_WRITE) begin
            pdata_q <= val_q ? (word_eff | blk_oh) : (word_eff & ~blk_oh);
          end else begin
            // free: count saturates at the total
            pdata_q <= word_eff & ~blk_oh;
            pbout_q <= blk_q;
            if (free_q < total_i) pcnt_q <= free_q + CNT_W'(1);
          end
        end
        PEND_ALLOC: begin
          paddr_q <= chk_q;
          pdata_q <= word_eff | (WORD_BITS'(1) << scan_pos);
          pcnt_q  <= free_q - CNT_W'(1);
          pbout_q <= {chk_q, scan_pos};
        end
        PEND_NOFREE: pst_q <= ST_NOFREE;
        PEND_RANGE:  pst_q <= ST_RANGE;
        PEND_NOP:    pst_q <= ST_OK;
        default:     pst_q <= ST_OK;
      endcase
    end

    if (cmd_i.commit) begin
      rsp_st_q  <= pst_q;
      rsp_blk_q <= pbout_q;
      rsp_bit_q <= pbit_q;
      rsp_cnt_q <= pcnt_q;
    end
  end

  assign rsp_valid_o  = rsp_vld_q;
  assign rsp_status_o = rsp_st_q;
  assign rsp_block_o  = rsp_blk_q;
  assign rsp_bit_o    = rsp_bit_q;
  assign rsp_free_o   = rsp_cnt_q;

endmodule

### rtl/bba_ctrl.sv
// Controller: sequences format, bit access, first-fit scan and commit.
// Depends on bba_pkg.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  bba_sts_t sts_i,
  output bba_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FMT_WR,
    S_MAP_MOD,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.pend_kind = PEND_NOP;
    req_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts_i.op == OP_FORMAT) begin
          cmd_o.clr_map = 1'b1;
          state_d       = S_FMT_WR;
        end else if (sts_i.op == OP_READ || sts_i.op == OP_WRITE ||
                     sts_i.op == OP_FREE) begin
          if (sts_i.in_range) begin
            state_d = S_MAP_MOD;      // map word read this cycle
          end else begin
            cmd_o.pend_en   = 1'b1;
            cmd_o.pend_kind = PEND_RANGE;
            state_d         = S_FINISH;
          end
        end else if (sts_i.op == OP_ALLOC) begin
          if (sts_i.free_zero || sts_i.total_zero) begin
            cmd_o.pend_en   = 1'b1;
            cmd_o.pend_kind = PEND_NOFREE;
            state_d         = S_FINISH;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else begin
          cmd_o.pend_en   = 1'b1;
          cmd_o.pend_kind = PEND_NOP;
          state_d         = S_FINISH;
        end
      end
      S_FMT_WR: begin
        if (sts_i.fmt_more) begin
          cmd_o.fmt_wr = 1'b1;
          // last map word: the pointer wraps, so stage the result now
          if (sts_i.fmt_last) begin
            cmd_o.pend_en   = 1'b1;
            cmd_o.pend_kind = PEND_FMT;
            state_d         = S_FINISH;
          end
        end else begin
          cmd_o.pend_en   = 1'b1;
          cmd_o.pend_kind = PEND_FMT;
          state_d         = S_FINISH;
        end
      end
      S_MAP_MOD: begin
        cmd_o.pend_en   = 1'b1;
        cmd_o.pend_kind = PEND_MOD;
        state_d         = S_FINISH;
      end
      S_SCAN: begin
        priority if (sts_i.scan_hit) begin
          cmd_o.pend_en   = 1'b1;
          cmd_o.pend_kind = PEND_ALLOC;
          state_d         = S_FINISH;
        end else if (sts_i.scan_last) begin
          cmd_o.pend_en   = 1'b1;
          cmd_o.pend_kind = PEND_NOFREE;
          state_d         = S_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/bitmap_block_allocator_unit.sv
// Top level of the bitmap block allocator: APB configuration registers,
// controller and datapath. Depends on bba_pkg, bba_if, bba_ctrl, bba_dp.
//
// Channel   Dir  Handshake            Word
// req_i     in   valid/ready          op, block_number, bit_value
// rsp_o     out  valid/ready          status, block_out, bit_read, free_count
// APB       in   psel/penable/pready  total_blocks @0x0, total_inodes @0x4
//
// One word at a time. Read bit, write bit and free go through dispatch,
// map read and finish; a range error or an unknown op skips the map read.
// Format clears the map and writes the metadata map words, one map word
// written per cycle; allocate finds the first free block by a
// one-word-per-cycle scan through the single map read port.
// Reset clears the map at once through per-word valid bits; no sweep.
// The response register lets a new word be accepted while a result waits;
// a finished word then holds in its commit cycle until rsp_o is free.
module bitmap_block_allocator_unit import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bba_req_if.sink           req_i,
  bba_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] cfg_total_q;
  logic [INO_W-1:0] cfg_inodes_q;
  logic [CNT_W-1:0] eff_total;
  logic             cfg_wr;

  bba_cmd_t cmd;
  bba_sts_t sts;

  // register write completes in the access phase; no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_total_q  <= TOTAL_RST;
      cfg_inodes_q <= INODES_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TOTAL) begin
        cfg_total_q <= pwdata[CNT_W-1:0];
      end else begin
        cfg_inodes_q <= pwdata[INO_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_INODES) ? APB_DW'(cfg_inodes_q) : APB_DW'(cfg_total_q);

  // block count clamps to the map size
  assign eff_total = (cfg_total_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_total_q;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (req_i.op),
    .blk_i        (req_i.block_number),
    .bit_val_i    (req_i.bit_value),
    .total_i      (eff_total),
    .inodes_i     (cfg_inodes_q),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_block_o  (rsp_o.block_out),
    .rsp_bit_o    (rsp_o.bit_read),
    .rsp_free_o   (rsp_o.free_count)
  );

endmodule

### tb/tb_bitmap_block_allocator_unit.sv
// Self-checking testbench for bitmap_block_allocator_unit: a directed table and
// random traffic on the request channel, checked word by word against a local map
// model. Depends on bba_pkg, bba_if and the RTL top level.
`timescale 1ns / 100ps

module tb_bitmap_block_allocator_unit;
  import bba_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int PHASE_WORDS   = 70;
  localparam int HOLD_CYCLES   = 400;   // long response stall, fills the block
  localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on req/rsp
  localparam int END_CYCLES    = 40;    // longest op latency, plus margin
  localparam int BITS_PER_BYTE = 8;

  // op codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] blk;
    logic             bit_rd;
    logic [CNT_W-1:0] count;
  } map_result_t;

  typedef struct packed {
    logic        has_ans;
    map_result_t res;
  } answer_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] blk;
    logic             val;
    answer_t          ans;
    logic [CNT_W-1:0] cfg_total;
    logic [INO_W-1:0] cfg_inodes;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  bitmap_block_allocator_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // local copy of the block state and registers
  logic [MAX_BLOCKS-1:0] used_map   = '0;
  int                    free_cnt   = 0;
  logic [CNT_W-1:0]      total_reg  = TOTAL_RST;
  logic [INO_W-1:0]      inodes_reg = INODES_RST;

  map_result_t due_results[$];    // results owed by the block, oldest first
  answer_t     table_results[$];  // typed answers, one per word offered
  stim_row_t   dir_tab[$];

  int   mismatches   = 0;
  int   idle_cycles  = 0;
  int   burst_left   = 0;
  bit   gaps_on      = 1'b1;
  bit   hold_pending = 1'b0;
  int   hold_left    = 0;
  int   rdy_mode     = 0;
  int   mode_left    = 0;
  int   pat_cnt      = 0;

  function automatic int eff_total();
    return (int'(total_reg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_reg);
  endfunction

  // Applies one op to the local map and returns the result word it yields.
  function automatic map_result_t next_map_result(input logic [OP_W-1:0]  op,
                                                  input logic [BLK_W-1:0] blk,
                                                  input logic             val);
    map_result_t r;
    int          total;
    int          meta;
    int          hit;
    r        = '0;
    r.status = ST_OK;
    total    = eff_total();
    case (op)
      OP_FORMAT: begin
        // superblock + block bitmap + inode table, clamped to the disk
        meta = 1 + (total / BITS_PER_BYTE + BLOCK_BYTES - 1) / BLOCK_BYTES
               + (int'(inodes_reg) * INODE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (meta > total) meta = total;
        used_map = '0;
        for (int i = 0; i < meta; i++) used_map[i] = 1'b1;
        free_cnt = total - meta;
      end
      OP_READ, OP_WRITE, OP_FREE: begin
        if (int'(blk) >= total) begin
          r.status = ST_RANGE;
        end else if (op == OP_READ) begin
          r.bit_rd = used_map[blk];
        end else if (op == OP_WRITE) begin
          used_map[blk] = val;
        end else begin
          // freeing a free block still bumps the count, up to the total
          used_map[blk] = 1'b0;
          if (free_cnt < total) free_cnt++;
          r.blk = blk;
        end
      end
      OP_ALLOC: begin
        hit = -1;
        if (free_cnt != 0) begin
          for (int i = total - 1; i >= 0; i--) if (!used_map[i]) hit = i;
        end
        if (hit >= 0) begin
          used_map[hit] = 1'b1;
          free_cnt--;
          r.blk = BLK_W'(hit);
        end else begin
          r.status = ST_NOFREE;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(free_cnt);
    return r;
  endfunction

  function automatic stim_row_t ans_row(input logic [OP_W-1:0] op, input int blk,
                                        input logic val, input logic [ST_W-1:0] st,
                                        input int bout, input logic rd, input int cnt);
    stim_row_t r;
    r                = '0;
    r.kind           = ROW_WORD;
    r.op             = op;
    r.blk            = BLK_W'(blk);
    r.val            = val;
    r.ans.has_ans    = 1'b1;
    r.ans.res.status = st;
    r.ans.res.blk    = BLK_W'(bout);
    r.ans.res.bit_rd = rd;
    r.ans.res.count  = CNT_W'(cnt);
    return r;
  endfunction

  function automatic stim_row_t pred_row(input logic [OP_W-1:0] op, input int blk,
                                         input logic val);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.op   = op;
    r.blk  = BLK_W'(blk);
    r.val  = val;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input int total, input int inodes);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_CFG;
    r.cfg_total  = CNT_W'(total);
    r.cfg_inodes = INO_W'(inodes);
    return r;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Offers one word; returns at the edge where it is taken. valid stays high
  // so a following word can go back to back.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                           input logic val, input answer_t ans);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    table_results.push_back(ans);
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.block_number <= blk;
    req_if.bit_value    <= val;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic logic [OP_W-1:0] OP_KIND_RSVD();
    return OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
  endfunction

  task automatic send_random_word();
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] blk;
    int               total;
    int               pick;
    total = eff_total();
    pick  = $urandom_range(0, 99);
    if (pick < 4)       op = OP_FORMAT;
    else if (pick < 36) op = OP_ALLOC;
    else if (pick < 60) op = OP_FREE;
    else if (pick < 74) op = OP_READ;
    else if (pick < 94) op = OP_WRITE;
    else                op = OP_KIND_RSVD();
    // mostly in range, often near the top so allocation scans far
    pick = $urandom_range(0, 9);
    if (total == 0 || pick == 0) begin
      blk = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
    end else if (pick < 4) begin
      blk = BLK_W'($urandom_range((total > 64) ? total - 64 : 0, total - 1));
    end else begin
      blk = BLK_W'($urandom_range(0, total - 1));
    end
    send_word(op, blk, 1'($urandom_range(0, 1)), '0);
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (due_results.size() == 0);
    @(posedge clk_i);
  endtask

  // One APB write; psel is left high so a second write can follow directly.
  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_TOTAL) total_reg = data[CNT_W-1:0];
    else                  inodes_reg = data[INO_W-1:0];
  endtask

  task automatic set_config(input int total, input int inodes);
    drain();
    write_reg(REG_TOTAL, APB_DW'(total));
    write_reg(REG_INODES, APB_DW'(inodes));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Response side: random stall modes, plus one long hold on request.
  always @(posedge clk_i) begin
    if (hold_pending) begin
      hold_left    = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      pat_cnt = (pat_cnt + 1) % 5;
      case (rdy_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= (pat_cnt >= 2);
        default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Predict on every accepted request word, check every accepted result word.
  always @(posedge clk_i) begin
    map_result_t pred;
    map_result_t want;
    answer_t     ans;
    bit          moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        pred  = next_map_result(req_if.op, req_if.block_number, req_if.bit_value);
        ans   = table_results.pop_front();
        due_results.push_back(ans.has_ans ? ans.res : pred);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (due_results.size() == 0) begin
          $display("%0t: result word with none expected, actual status %0d block %0d",
                   $time, rsp_if.status, rsp_if.block_out);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, rsp_if.status);
          check_field("block_out", want.blk, rsp_if.block_out);
          check_field("bit_read", want.bit_rd, rsp_if.bit_read);
          check_field("free_count", want.count, rsp_if.free_count);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("** bitmap_block_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_FORMAT;
    req_if.block_number = '0;
    req_if.bit_value    = 1'b0;
    rsp_if.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;

    // (op, block, value, status, block_out, bit_read, free_count)
    dir_tab = '{
      // after reset: empty map, zero count, default registers
      ans_row(OP_READ,    0,    1'b0, ST_OK,     0,    1'b0, 0),
      ans_row(OP_ALLOC,   0,    1'b0, ST_NOFREE, 0,    1'b0, 0),
      ans_row(OP_FREE,    1023, 1'b0, ST_OK,     1023, 1'b0, 1),
      // 1024 blocks, 256 inodes: 34 metadata blocks
      ans_row(OP_FORMAT,  0,    1'b0, ST_OK,     0,    1'b0, 990),
      ans_row(OP_READ,    33,   1'b0, ST_OK,     0,    1'b1, 990),
      ans_row(OP_READ,    34,   1'b0, ST_OK,     0,    1'b0, 990),
      ans_row(OP_ALLOC,   0,    1'b0, ST_OK,     34,   1'b0, 989),
      pred_row(OP_WRITE,  1023, 1'b1),
      ans_row(OP_READ,    1023, 1'b0, ST_OK,     0,    1'b1, 989),
      pred_row(OP_WRITE,  34,   1'b0),
      ans_row(OP_FREE,    35,   1'b0, ST_OK,     35,   1'b0, 990),
      ans_row(OP_RSVD_LO, 0,    1'b1, ST_OK,     0,    1'b0, 990),
      ans_row(OP_RSVD_HI, 1023, 1'b1, ST_OK,     0,    1'b0, 990),
      // small disk: range errors, count saturating at the total
      cfg_row(16, 0),
      ans_row(OP_FORMAT,  0,    1'b0, ST_OK,     0,    1'b0, 14),
      ans_row(OP_READ,    16,   1'b0, ST_RANGE,  0,    1'b0, 14),
      ans_row(OP_WRITE,   1023, 1'b1, ST_RANGE,  0,    1'b0, 14),
      ans_row(OP_FREE,    16,   1'b0, ST_RANGE,  0,    1'b0, 14),
      ans_row(OP_FREE,    15,   1'b0, ST_OK,     15,   1'b0, 15),
      ans_row(OP_FREE,    0,    1'b0, ST_OK,     0,    1'b0, 16),
      ans_row(OP_FREE,    15,   1'b0, ST_OK,     15,   1'b0, 16),
      // metadata larger than the disk; nonzero count with a full map
      cfg_row(2047, 8191),
      ans_row(OP_FORMAT,  0,    1'b0, ST_OK,     0,    1'b0, 0),
      ans_row(OP_ALLOC,   0,    1'b0, ST_NOFREE, 0,    1'b0, 0),
      ans_row(OP_FREE,    5,    1'b0, ST_OK,     5,    1'b0, 1),
      pred_row(OP_WRITE,  5,    1'b1),
      ans_row(OP_ALLOC,   0,    1'b0, ST_NOFREE, 0,    1'b0, 1),
      // empty disk
      cfg_row(0, 0),
      ans_row(OP_FORMAT,  0,    1'b0, ST_OK,     0,    1'b0, 0),
      ans_row(OP_ALLOC,   0,    1'b0, ST_NOFREE, 0,    1'b0, 0)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_config(dir_tab[i].cfg_total, dir_tab[i].cfg_inodes);
      end else begin
        send_word(dir_tab[i].op, dir_tab[i].blk, dir_tab[i].val, dir_tab[i].ans);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_config(1024, 7000);  // free space starts in map word 27
        1:       set_config(40, 2);
        2:       set_config(2047, 8100);  // only the last few blocks free
        3:       set_config(64, 0);
        4:       set_config(1, 0);
        default: set_config($urandom_range(0, 2047), $urandom_range(0, 300));
      endcase
      gaps_on = (p != 2);
      if (p == 0) hold_pending = 1'b1;
      send_word(OP_FORMAT, '0, 1'b0, '0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 3 && n == PHASE_WORDS / 2) drain();
        send_random_word();
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("** bitmap_block_allocator_unit: PASSED **");
    end else begin
      $display("** bitmap_block_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_dp.sv
rtl/bba_ctrl.sv
rtl/bitmap_block_allocator_unit.sv
tb/tb_bitmap_block_allocator_unit.sv
